// ===== hw/rtl/pcbd_pkg.sv =====
// Package for the pulse-count backlight dimmer.
// Holds widths, register indexes, the panel step tables and the level mapping function.
// No dependencies.
package pcbd_pkg;

   localparam int DimSteps     = 32;
   localparam int StepBits     = $clog2(DimSteps);
   localparam int TableEntries = 21;
   localparam int TableRows    = 32;
   localparam int LevelBits    = 8;
   localparam int UsedRows     = (TableEntries > TableRows) ? TableRows : TableEntries;

   typedef logic [StepBits-1:0]  step_type;
   typedef logic [LevelBits-1:0] level_type;
   typedef logic [1:0]           panel_type;

   typedef enum logic [1:0] {
      CsrPanelTable   = 2'd0,
      CsrDimThreshold = 2'd1,
      CsrDimStep      = 2'd2,
      CsrUnused       = 2'd3
   } csr_index_type;

   localparam panel_type PanelDefault = 2'd0;
   localparam panel_type PanelPwm     = 2'd3;

   typedef struct packed {
      panel_type panel_table;
      level_type dim_threshold;
      step_type  dim_step;
   } cfg_type;

   typedef struct packed {
      step_type  step_value;
      step_type  pulse_count;
      logic      hold_low_first;
      logic      raise_first;
      logic      pwm_mode;
   } rsp_type;

   typedef level_type [TableRows-1:0] lvl_row_type;
   typedef step_type  [TableRows-1:0] stp_row_type;

   // rows beyond the listed ones read as zero; entry 0 sits in bit slot 0
   localparam lvl_row_type DefaultLvl = {
      {11{8'd0}},
      8'd0,   8'd20,  8'd35,  8'd43,  8'd50,  8'd63,  8'd76,  8'd89,  8'd102, 8'd115,
      8'd130, 8'd145, 8'd155, 8'd168, 8'd180, 8'd195, 8'd205, 8'd215, 8'd230, 8'd240,
      8'd255
   };
   localparam stp_row_type DefaultStp = {
      {11{5'd0}},
      5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
      5'd22, 5'd21, 5'd20, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12,
      5'd11
   };
   localparam lvl_row_type StandardLvl = {
      {11{8'd0}},
      8'd0,   8'd20,  8'd30,  8'd38,  8'd46,  8'd54,  8'd62,  8'd70,  8'd78,  8'd86,
      8'd94,  8'd98,  8'd102, 8'd121, 8'd140, 8'd159, 8'd178, 8'd197, 8'd216, 8'd235,
      8'd255
   };
   localparam stp_row_type StandardStp = {
      {11{5'd0}},
      5'd0,  5'd31, 5'd31, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
      5'd22, 5'd20, 5'd18, 5'd16, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9,
      5'd7
   };

   // First row pair whose band holds the level wins; no band means off.
   function automatic step_type map_level(level_type level, logic use_default);
      lvl_row_type lvl;
      stp_row_type stp;
      step_type    res;
      lvl = use_default ? DefaultLvl : StandardLvl;
      stp = use_default ? DefaultStp : StandardStp;
      res = '0;
      for (int i = UsedRows - 2; i >= 0; i--) begin
         if (level <= lvl[i] && level > lvl[i+1]) begin
            res = stp[i];
         end
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/pcbd_csr.sv =====
// Configuration registers of the backlight dimmer.
// Uses pcbd_pkg for the register indexes and the cfg_type struct.
module pcbd_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   output pcbd_pkg::cfg_type      cfg
);

   pcbd_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pcbd_pkg::csr_index_type'(csr_index))
            pcbd_pkg::CsrPanelTable:   cfg_in.panel_table   = csr_wdata[1:0];
            pcbd_pkg::CsrDimThreshold: cfg_in.dim_threshold = csr_wdata;
            pcbd_pkg::CsrDimStep:      cfg_in.dim_step      = csr_wdata[pcbd_pkg::StepBits-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.panel_table   <= pcbd_pkg::PanelDefault;
         cfg_ff.dim_threshold <= 8'd20;
         cfg_ff.dim_step      <= 5'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/pcbd_map.sv =====
// Level to dimmer step mapping: dimming range check and panel table lookup.
// Uses pcbd_pkg for the tables and map_level.
module pcbd_map (
   input  pcbd_pkg::cfg_type      cfg,
   input  pcbd_pkg::level_type    level,
   output pcbd_pkg::step_type     tune,
   output logic                   pwm
);

   pcbd_pkg::step_type table_step;

   assign pwm        = (cfg.panel_table == pcbd_pkg::PanelPwm);
   assign table_step = pcbd_pkg::map_level(level, cfg.panel_table == pcbd_pkg::PanelDefault);

   always_comb begin
      tune = '0;
      if (level != '0) begin
         if (level < cfg.dim_threshold && !pwm) begin
            tune = cfg.dim_step;
         end else begin
            tune = table_step;
         end
      end
   end

endmodule

// ===== hw/rtl/pcbd_track.sv =====
// Tracks the dimmer chip's current step and works out the pulse count and pin preamble.
// Uses pcbd_pkg for step_type and rsp_type.
module pcbd_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  pcbd_pkg::step_type     tune,
   input  logic                   pwm,
   input  logic                   pin_high,
   output pcbd_pkg::rsp_type      rsp
);

   pcbd_pkg::step_type cur_ff, cur_in;
   logic               known_ff, known_in;
   logic               known_eff;
   pcbd_pkg::step_type cur_eff;

   // a high pin with unknown step means: force off, then start from step 0
   assign known_eff = known_ff | pin_high;
   assign cur_eff   = known_ff ? cur_ff : '0;

   always_comb begin
      rsp.step_value     = tune;
      rsp.pwm_mode       = pwm;
      rsp.pulse_count    = '0;
      rsp.hold_low_first = 1'b0;
      rsp.raise_first    = 1'b0;
      if (pwm || tune == '0) begin
         rsp.hold_low_first = !pwm;
      end else begin
         rsp.hold_low_first = !known_ff && pin_high;
         if (!known_eff) begin
            // chip assumed one step above the top
            rsp.pulse_count = tune + pcbd_pkg::step_type'(1);
         end else begin
            // step 0 wakes at the top step, which is 0 modulo the step count
            rsp.raise_first = (cur_eff == '0);
            rsp.pulse_count = tune - cur_eff;
         end
      end
   end

   always_comb begin
      cur_in   = cur_ff;
      known_in = known_ff;
      if (update) begin
         cur_in   = tune;
         known_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         known_ff <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         known_ff <= known_in;
      end
   end

   a_known_after_update: assert property (@(posedge clock) disable iff (reset)
      update |=> known_ff)
      else $error("step not known after an item");

   a_step_recorded: assert property (@(posedge clock) disable iff (reset)
      update |=> cur_ff == $past(tune))
      else $error("current step not recorded");

   a_raise_needs_target: assert property (@(posedge clock) disable iff (reset)
      rsp.raise_first |-> (rsp.step_value != '0 && !rsp.pwm_mode))
      else $error("raise without a target step");

   a_pwm_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp.pwm_mode |-> (rsp.pulse_count == '0 && !rsp.hold_low_first && !rsp.raise_first))
      else $error("pin activity in PWM mode");

endmodule

// ===== hw/rtl/pulse_count_backlight_dimmer.sv =====
// Top level of the pulse-count backlight dimmer: input stage, result register and glue.
// Depends on pcbd_pkg, pcbd_csr, pcbd_map and pcbd_track.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_level[7:0], req_pin_high
//   rsp      out        rsp_valid/rsp_ready  rsp_step_value[4:0], rsp_pulse_count[4:0],
//                                            rsp_hold_low_first, rsp_raise_first, rsp_pwm_mode
//   csr      in         csr_valid/csr_ready  csr_index[1:0], csr_wdata[7:0]
//
// An accepted item is held in the input register, then the table lookup and step tracking
// land it in the result register. One item per cycle sustained while the result is taken.
// Reset is synchronous; it restores the register defaults and clears the current step and
// the valid flags.
// A stalled result holds the input stage; req_ready drops only when both stages are full
// and the result is stalled.
module pulse_count_backlight_dimmer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_level,
   input  logic        req_pin_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_step_value,
   output logic [4:0]  rsp_pulse_count,
   output logic        rsp_hold_low_first,
   output logic        rsp_raise_first,
   output logic        rsp_pwm_mode,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   pcbd_pkg::cfg_type   cfg;
   pcbd_pkg::step_type  tune;
   logic                pwm;
   pcbd_pkg::rsp_type   rsp_calc;

   logic                s1_valid_ff, s1_valid_in;
   pcbd_pkg::level_type s1_level_ff, s1_level_in;
   logic                s1_pin_ff, s1_pin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pcbd_pkg::rsp_type   rsp_ff, rsp_in;

   logic out_free;
   logic advance;
   logic take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   pcbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcbd_map u_map (
      .cfg   (cfg),
      .level (s1_level_ff),
      .tune  (tune),
      .pwm   (pwm)
   );

   pcbd_track u_track (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .tune     (tune),
      .pwm      (pwm),
      .pin_high (s1_pin_ff),
      .rsp      (rsp_calc)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_level_in = s1_level_ff;
      s1_pin_in   = s1_pin_ff;
      if (take) begin
         s1_valid_in = 1'b1;
         s1_level_in = req_level;
         s1_pin_in   = req_pin_high;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_calc;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= s1_level_in;
      s1_pin_ff   <= s1_pin_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_value     = rsp_ff.step_value;
   assign rsp_pulse_count    = rsp_ff.pulse_count;
   assign rsp_hold_low_first = rsp_ff.hold_low_first;
   assign rsp_raise_first    = rsp_ff.raise_first;
   assign rsp_pwm_mode       = rsp_ff.pwm_mode;

endmodule
